### src/lav_pkg.sv
`timescale 1ns / 1ps

package lav_pkg;

   // number format and default fraction width
   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_W        = 32;
   localparam int DIFF_W        = WORD_W + 1;

   // normaliser internals
   localparam int VEC_W          = 64;
   localparam int MAG_W          = VEC_W - 1;
   localparam int BL_W           = 7;
   localparam int A_W            = 30;
   localparam int SQ_W           = 2 * A_W + 2;
   localparam int ROOT_W         = 32;
   localparam int ROOT_STEPS     = SQ_W / 2 + 1;
   localparam int ROOT_PER_STAGE = 2;
   localparam int ROOT_STAGES    = ROOT_STEPS / ROOT_PER_STAGE;
   localparam int RECIP_W        = 33;
   localparam int REM_W          = 33;
   localparam int RECIP_ONE_POS  = 61;
   localparam int DIV_PER_STAGE  = 3;
   localparam int DIV_STAGES     = RECIP_W / DIV_PER_STAGE;
   localparam int PROD_W         = A_W + RECIP_W;

   // matrix rows
   localparam logic [1:0] ROW_RIGHT = 2'd0;
   localparam logic [1:0] ROW_UP    = 2'd1;
   localparam logic [1:0] ROW_FWD   = 2'd2;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
   } vec_type;

   typedef struct packed {
      word_type eye_x;
      word_type eye_y;
      word_type eye_z;
      word_type target_x;
      word_type target_y;
      word_type target_z;
      word_type up_x;
      word_type up_y;
      word_type up_z;
   } req_type;

   typedef struct packed {
      logic [1:0] row_index;
      word_type   col_x;
      word_type   col_y;
      word_type   col_z;
      word_type   col_w;
      logic       last_row;
      logic       degenerate;
   } rsp_type;

endpackage

### src/look_at_view_matrix.sv
`timescale 1ns / 1ps

// look-at view matrix builder, right handed, signed fixed point
// req channel: one transfer carries eye, target and up vectors.
// rsp channel: three transfers per request, rows in order right, camera up,
// forward; each holds the unit vector and the dot of eye with it. last_row
// marks the forward row, degenerate is set on all three rows when any vector
// to normalise had zero length.
// throughput: one request may enter the pipeline every cycle while the output
// buffer is empty; once it holds a request, the pipeline moves only when its
// forward row transfers, so the three-row output buffer sets the sustained rate.
// the path is three normalisers in series, each 34 stages (square root at
// two bits per stage, reciprocal division at three bits per stage).
// reset (synchronous) empties every stage and the output buffer.
// rsp_stall with a row held freezes the whole pipeline and that row; nothing is
// lost or repeated; req_stall is high in reset and while the buffer cannot reload.
module look_at_view_matrix #(
   parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lav_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lav_pkg::rsp_type rsp_data
);
   import lav_pkg::*;

   localparam int VW  = 3 * WORD_W;
   localparam int SF_W = 2 * VW;
   localparam int SR_W = 2 * VW + 1;
   localparam int SU_W = 3 * VW + 1;
   localparam logic [VEC_W-1:0] SAT_NEG = VEC_W'(64'h8000_0000);
   localparam logic [VEC_W-1:0] SAT_POS = VEC_W'(64'h7FFF_FFFF);

   logic advance;
   logic ob_valid_ff;
   logic [1:0] ob_row_ff;

   // whole pipeline moves when the output buffer can be reloaded
   assign advance   = !ob_valid_ff || (!rsp_stall && ob_row_ff == ROW_FWD);
   assign req_stall = reset || !advance;

   // input stage: capture and form eye - target
   logic                         i0_valid_ff;
   vec_type                      i0_eye_ff;
   vec_type                      i0_up_ff;
   logic [2:0][DIFF_W-1:0]       i0_diff_ff;
   logic [2:0][DIFF_W-1:0]       diff_in;

   always_comb begin
      diff_in[0] = {req_data.eye_x[WORD_W-1], req_data.eye_x}
                 - {req_data.target_x[WORD_W-1], req_data.target_x};
      diff_in[1] = {req_data.eye_y[WORD_W-1], req_data.eye_y}
                 - {req_data.target_y[WORD_W-1], req_data.target_y};
      diff_in[2] = {req_data.eye_z[WORD_W-1], req_data.eye_z}
                 - {req_data.target_z[WORD_W-1], req_data.target_z};
   end

   always_ff @(posedge clock) begin
      if (reset) i0_valid_ff <= 1'b0;
      else if (advance) i0_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         i0_eye_ff.x <= req_data.eye_x;
         i0_eye_ff.y <= req_data.eye_y;
         i0_eye_ff.z <= req_data.eye_z;
         i0_up_ff.x  <= req_data.up_x;
         i0_up_ff.y  <= req_data.up_y;
         i0_up_ff.z  <= req_data.up_z;
         i0_diff_ff  <= diff_in;
      end
   end

   // forward = normalise(eye - target)
   logic [2:0][VEC_W-1:0] nf_vec;
   logic                  nf_valid;
   vec_type               nf_unit;
   logic                  nf_zero;
   logic [SF_W-1:0]       nf_side;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nf_vec[i] = {{(VEC_W-DIFF_W){i0_diff_ff[i][DIFF_W-1]}}, i0_diff_ff[i]};
      end
   end

   lav_nrm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SF_W)) u_nrm_fwd (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (i0_valid_ff),
      .in_vec   (nf_vec),
      .in_side  ({i0_eye_ff, i0_up_ff}),
      .out_valid(nf_valid),
      .out_unit (nf_unit),
      .out_zero (nf_zero),
      .out_side (nf_side)
   );

   // up x forward: products, then differences
   vec_type nf_eye;
   vec_type nf_up;
   assign nf_eye = vec_type'(nf_side[SF_W-1:VW]);
   assign nf_up  = vec_type'(nf_side[VW-1:0]);

   logic                    c1a_valid_ff;
   logic signed [VEC_W-1:0] c1a_p_ff [6];
   vec_type                 c1a_eye_ff;
   vec_type                 c1a_fwd_ff;
   logic                    c1a_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) c1a_valid_ff <= 1'b0;
      else if (advance) c1a_valid_ff <= nf_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c1a_p_ff[0] <= $signed(nf_up.y) * $signed(nf_unit.z);
         c1a_p_ff[1] <= $signed(nf_up.z) * $signed(nf_unit.y);
         c1a_p_ff[2] <= $signed(nf_up.z) * $signed(nf_unit.x);
         c1a_p_ff[3] <= $signed(nf_up.x) * $signed(nf_unit.z);
         c1a_p_ff[4] <= $signed(nf_up.x) * $signed(nf_unit.y);
         c1a_p_ff[5] <= $signed(nf_up.y) * $signed(nf_unit.x);
         c1a_eye_ff  <= nf_eye;
         c1a_fwd_ff  <= nf_unit;
         c1a_deg_ff  <= nf_zero;
      end
   end

   logic                  c1b_valid_ff;
   logic [2:0][VEC_W-1:0] c1b_c_ff;
   vec_type               c1b_eye_ff;
   vec_type               c1b_fwd_ff;
   logic                  c1b_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) c1b_valid_ff <= 1'b0;
      else if (advance) c1b_valid_ff <= c1a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c1b_c_ff[0] <= c1a_p_ff[0] - c1a_p_ff[1];
         c1b_c_ff[1] <= c1a_p_ff[2] - c1a_p_ff[3];
         c1b_c_ff[2] <= c1a_p_ff[4] - c1a_p_ff[5];
         c1b_eye_ff  <= c1a_eye_ff;
         c1b_fwd_ff  <= c1a_fwd_ff;
         c1b_deg_ff  <= c1a_deg_ff;
      end
   end

   // right = normalise(up x forward)
   logic            nr_valid;
   vec_type         nr_unit;
   logic            nr_zero;
   logic [SR_W-1:0] nr_side;

   lav_nrm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SR_W)) u_nrm_right (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (c1b_valid_ff),
      .in_vec   (c1b_c_ff),
      .in_side  ({c1b_eye_ff, c1b_fwd_ff, c1b_deg_ff}),
      .out_valid(nr_valid),
      .out_unit (nr_unit),
      .out_zero (nr_zero),
      .out_side (nr_side)
   );

   // forward x right: products, then differences
   vec_type nr_eye;
   vec_type nr_fwd;
   assign nr_eye = vec_type'(nr_side[SR_W-1:VW+1]);
   assign nr_fwd = vec_type'(nr_side[VW:1]);

   logic                    c2a_valid_ff;
   logic signed [VEC_W-1:0] c2a_p_ff [6];
   vec_type                 c2a_eye_ff;
   vec_type                 c2a_fwd_ff;
   vec_type                 c2a_right_ff;
   logic                    c2a_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) c2a_valid_ff <= 1'b0;
      else if (advance) c2a_valid_ff <= nr_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c2a_p_ff[0]  <= $signed(nr_fwd.y) * $signed(nr_unit.z);
         c2a_p_ff[1]  <= $signed(nr_fwd.z) * $signed(nr_unit.y);
         c2a_p_ff[2]  <= $signed(nr_fwd.z) * $signed(nr_unit.x);
         c2a_p_ff[3]  <= $signed(nr_fwd.x) * $signed(nr_unit.z);
         c2a_p_ff[4]  <= $signed(nr_fwd.x) * $signed(nr_unit.y);
         c2a_p_ff[5]  <= $signed(nr_fwd.y) * $signed(nr_unit.x);
         c2a_eye_ff   <= nr_eye;
         c2a_fwd_ff   <= nr_fwd;
         c2a_right_ff <= nr_unit;
         c2a_deg_ff   <= nr_side[0] | nr_zero;
      end
   end

   logic                  c2b_valid_ff;
   logic [2:0][VEC_W-1:0] c2b_c_ff;
   vec_type               c2b_eye_ff;
   vec_type               c2b_fwd_ff;
   vec_type               c2b_right_ff;
   logic                  c2b_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) c2b_valid_ff <= 1'b0;
      else if (advance) c2b_valid_ff <= c2a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c2b_c_ff[0]  <= c2a_p_ff[0] - c2a_p_ff[1];
         c2b_c_ff[1]  <= c2a_p_ff[2] - c2a_p_ff[3];
         c2b_c_ff[2]  <= c2a_p_ff[4] - c2a_p_ff[5];
         c2b_eye_ff   <= c2a_eye_ff;
         c2b_fwd_ff   <= c2a_fwd_ff;
         c2b_right_ff <= c2a_right_ff;
         c2b_deg_ff   <= c2a_deg_ff;
      end
   end

   // camera up = normalise(forward x right)
   logic            nu_valid;
   vec_type         nu_unit;
   logic            nu_zero;
   logic [SU_W-1:0] nu_side;

   lav_nrm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SU_W)) u_nrm_up (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (c2b_valid_ff),
      .in_vec   (c2b_c_ff),
      .in_side  ({c2b_eye_ff, c2b_fwd_ff, c2b_right_ff, c2b_deg_ff}),
      .out_valid(nu_valid),
      .out_unit (nu_unit),
      .out_zero (nu_zero),
      .out_side (nu_side)
   );

   // dot products of eye with each row: products
   vec_type nu_eye;
   vec_type nu_rows [3];
   assign nu_eye     = vec_type'(nu_side[SU_W-1:2*VW+1]);
   assign nu_rows[0] = vec_type'(nu_side[VW:1]);
   assign nu_rows[1] = nu_unit;
   assign nu_rows[2] = vec_type'(nu_side[2*VW:VW+1]);

   logic                    d1_valid_ff;
   logic signed [VEC_W-1:0] d1_p_ff [3][3];
   vec_type                 d1_rows_ff [3];
   logic                    d1_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) d1_valid_ff <= 1'b0;
      else if (advance) d1_valid_ff <= nu_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            d1_p_ff[r][0] <= $signed(nu_eye.x) * $signed(nu_rows[r].x);
            d1_p_ff[r][1] <= $signed(nu_eye.y) * $signed(nu_rows[r].y);
            d1_p_ff[r][2] <= $signed(nu_eye.z) * $signed(nu_rows[r].z);
            d1_rows_ff[r] <= nu_rows[r];
         end
         d1_deg_ff <= nu_side[0] | nu_zero;
      end
   end

   // dot products: sum, round half away from zero, saturate
   word_type w_in [3];

   always_comb begin
      logic signed [VEC_W-1:0] sum;
      logic [VEC_W-1:0]        mag;
      logic [VEC_W-1:0]        qv;
      for (int r = 0; r < 3; r++) begin
         sum = d1_p_ff[r][0] + d1_p_ff[r][1] + d1_p_ff[r][2];
         mag = sum[VEC_W-1] ? VEC_W'(-sum) : VEC_W'(sum);
         qv  = (mag + (VEC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
         if (sum[VEC_W-1]) begin
            w_in[r] = (qv > SAT_NEG) ? WORD_W'(SAT_NEG) : WORD_W'(-qv);
         end else begin
            w_in[r] = (qv > SAT_POS) ? WORD_W'(SAT_POS) : WORD_W'(qv);
         end
      end
   end

   logic     d2_valid_ff;
   vec_type  d2_rows_ff [3];
   word_type d2_w_ff [3];
   logic     d2_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) d2_valid_ff <= 1'b0;
      else if (advance) d2_valid_ff <= d1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d2_rows_ff <= d1_rows_ff;
         d2_w_ff    <= w_in;
         d2_deg_ff  <= d1_deg_ff;
      end
   end

   // output buffer: holds one request's three rows, sends one per transfer
   vec_type  ob_rows_ff [3];
   word_type ob_w_ff [3];
   logic     ob_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_valid_ff <= 1'b0;
         ob_row_ff   <= ROW_RIGHT;
      end else if (advance) begin
         ob_valid_ff <= d2_valid_ff;
         ob_row_ff   <= ROW_RIGHT;
      end else if (ob_valid_ff && !rsp_stall) begin
         ob_row_ff   <= ob_row_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ob_rows_ff <= d2_rows_ff;
         ob_w_ff    <= d2_w_ff;
         ob_deg_ff  <= d2_deg_ff;
      end
   end

   // row select
   vec_type  sel_row;
   word_type sel_w;

   always_comb begin
      case (ob_row_ff)
         ROW_RIGHT: begin
            sel_row = ob_rows_ff[0];
            sel_w   = ob_w_ff[0];
         end
         ROW_UP: begin
            sel_row = ob_rows_ff[1];
            sel_w   = ob_w_ff[1];
         end
         default: begin
            sel_row = ob_rows_ff[2];
            sel_w   = ob_w_ff[2];
         end
      endcase
   end

   assign rsp_valid           = ob_valid_ff;
   assign rsp_data.row_index  = ob_row_ff;
   assign rsp_data.col_x      = sel_row.x;
   assign rsp_data.col_y      = sel_row.y;
   assign rsp_data.col_z      = sel_row.z;
   assign rsp_data.col_w      = sel_w;
   assign rsp_data.last_row   = (ob_row_ff == ROW_FWD);
   assign rsp_data.degenerate = ob_deg_ff;

endmodule

### src/lav_nrm.sv
`timescale 1ns / 1ps

module lav_nrm #(
   parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
   parameter int SIDE_W    = 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic [2:0][lav_pkg::VEC_W-1:0]      in_vec,
   input  logic [SIDE_W-1:0]                   in_side,
   output logic                                out_valid,
   output lav_pkg::vec_type                    out_unit,
   output logic                                out_zero,
   output logic [SIDE_W-1:0]                   out_side
);
   import lav_pkg::*;

   localparam int CW = SIDE_W + 4 + 3 * A_W;

   // stage 0: magnitudes, signs and bit length of the largest
   logic [2:0][MAG_W-1:0] mag_in;
   logic [MAG_W-1:0]      max_in;
   logic [BL_W-1:0]       bl_in;
   logic                  s0_valid_ff;
   logic [2:0][MAG_W-1:0] s0_mag_ff;
   logic [2:0]            s0_neg_ff;
   logic [BL_W-1:0]       s0_bl_ff;
   logic [SIDE_W-1:0]     s0_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = in_vec[i][VEC_W-1] ? MAG_W'(-in_vec[i]) : MAG_W'(in_vec[i]);
      end
      max_in = mag_in[0];
      if (mag_in[1] > max_in) max_in = mag_in[1];
      if (mag_in[2] > max_in) max_in = mag_in[2];
      bl_in = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (max_in[b]) bl_in = BL_W'(b + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s0_valid_ff <= 1'b0;
      else if (advance) s0_valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_mag_ff  <= mag_in;
         s0_bl_ff   <= bl_in;
         s0_side_ff <= in_side;
         for (int i = 0; i < 3; i++) s0_neg_ff[i] <= in_vec[i][VEC_W-1];
      end
   end

   // stage 1: scale so the largest magnitude sits just below 2^30
   logic [2:0][A_W-1:0] a_in;
   logic                s1_valid_ff;
   logic [2:0][A_W-1:0] s1_a_ff;
   logic [2:0]          s1_neg_ff;
   logic                s1_zero_ff;
   logic [SIDE_W-1:0]   s1_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (s0_bl_ff > BL_W'(A_W)) a_in[i] = A_W'(s0_mag_ff[i] >> (s0_bl_ff - BL_W'(A_W)));
         else a_in[i] = A_W'(s0_mag_ff[i] << (BL_W'(A_W) - s0_bl_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (advance) s1_valid_ff <= s0_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_a_ff    <= a_in;
         s1_neg_ff  <= s0_neg_ff;
         s1_zero_ff <= (s0_bl_ff == '0);
         s1_side_ff <= s0_side_ff;
      end
   end

   // stage 2: squares
   logic                    s2_valid_ff;
   logic [2:0][2*A_W-1:0]   s2_sq_ff;
   logic [CW-1:0]           s2_carry_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (advance) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            s2_sq_ff[i] <= (2*A_W)'(s1_a_ff[i]) * (2*A_W)'(s1_a_ff[i]);
         end
         s2_carry_ff <= {s1_side_ff, s1_neg_ff, s1_zero_ff, s1_a_ff};
      end
   end

   // square root, two result bits per stage; entry 0 holds the sum of squares
   logic              rt_valid_ff [ROOT_STAGES+1];
   logic [SQ_W-1:0]   rt_s_ff     [ROOT_STAGES+1];
   logic [VEC_W-1:0]  rt_r_ff     [ROOT_STAGES+1];
   logic [CW-1:0]     rt_carry_ff [ROOT_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) rt_valid_ff[0] <= 1'b0;
      else if (advance) rt_valid_ff[0] <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rt_s_ff[0]     <= SQ_W'(s2_sq_ff[0]) + SQ_W'(s2_sq_ff[1]) + SQ_W'(s2_sq_ff[2]);
         rt_r_ff[0]     <= '0;
         rt_carry_ff[0] <= s2_carry_ff;
      end
   end

   for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
      logic [SQ_W-1:0]  s_in;
      logic [VEC_W-1:0] r_in;

      always_comb begin
         logic [VEC_W-1:0] trial;
         logic [VEC_W-1:0] bitv;
         s_in = rt_s_ff[g];
         r_in = rt_r_ff[g];
         for (int k = 0; k < ROOT_PER_STAGE; k++) begin
            bitv  = VEC_W'(1) << (SQ_W - 2 * (g * ROOT_PER_STAGE + k));
            trial = r_in + bitv;
            if (VEC_W'(s_in) >= trial) begin
               s_in = SQ_W'(VEC_W'(s_in) - trial);
               r_in = (r_in >> 1) + bitv;
            end else begin
               r_in = r_in >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) rt_valid_ff[g+1] <= 1'b0;
         else if (advance) rt_valid_ff[g+1] <= rt_valid_ff[g];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rt_s_ff[g+1]     <= s_in;
            rt_r_ff[g+1]     <= r_in;
            rt_carry_ff[g+1] <= rt_carry_ff[g];
         end
      end
   end

   // reciprocal by restoring division, three quotient bits per stage
   logic               dv_valid_ff [DIV_STAGES+1];
   logic [REM_W-1:0]   dv_rem_ff   [DIV_STAGES+1];
   logic [RECIP_W-1:0] dv_q_ff     [DIV_STAGES+1];
   logic [RECIP_W-1:0] dv_num_ff   [DIV_STAGES+1];
   logic [ROOT_W-1:0]  dv_len_ff   [DIV_STAGES+1];
   logic [CW-1:0]      dv_carry_ff [DIV_STAGES+1];
   logic [ROOT_W-1:0]  len_in;

   assign len_in = ROOT_W'(rt_r_ff[ROOT_STAGES]);

   always_ff @(posedge clock) begin
      if (reset) dv_valid_ff[0] <= 1'b0;
      else if (advance) dv_valid_ff[0] <= rt_valid_ff[ROOT_STAGES];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_rem_ff[0]   <= REM_W'(1) << (RECIP_ONE_POS - RECIP_W);
         dv_q_ff[0]     <= '0;
         dv_num_ff[0]   <= RECIP_W'(len_in >> 1);
         dv_len_ff[0]   <= len_in;
         dv_carry_ff[0] <= rt_carry_ff[ROOT_STAGES];
      end
   end

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      logic [REM_W-1:0]   rem_in;
      logic [RECIP_W-1:0] q_in;

      always_comb begin
         rem_in = dv_rem_ff[g];
         q_in   = dv_q_ff[g];
         for (int k = 0; k < DIV_PER_STAGE; k++) begin
            rem_in = {rem_in[REM_W-2:0],
                      dv_num_ff[g][RECIP_W - 1 - (g * DIV_PER_STAGE + k)]};
            if (rem_in >= REM_W'(dv_len_ff[g])) begin
               rem_in = rem_in - REM_W'(dv_len_ff[g]);
               q_in[RECIP_W - 1 - (g * DIV_PER_STAGE + k)] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_valid_ff[g+1] <= 1'b0;
         else if (advance) dv_valid_ff[g+1] <= dv_valid_ff[g];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dv_rem_ff[g+1]   <= rem_in;
            dv_q_ff[g+1]     <= q_in;
            dv_num_ff[g+1]   <= dv_num_ff[g];
            dv_len_ff[g+1]   <= dv_len_ff[g];
            dv_carry_ff[g+1] <= dv_carry_ff[g];
         end
      end
   end

   // scale each magnitude by the reciprocal
   logic                   ml_valid_ff;
   logic [2:0][PROD_W-1:0] ml_prod_ff;
   logic [CW-1:0]          ml_carry_ff;
   logic [2:0][A_W-1:0]    dv_a;

   assign dv_a = dv_carry_ff[DIV_STAGES][3*A_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) ml_valid_ff <= 1'b0;
      else if (advance) ml_valid_ff <= dv_valid_ff[DIV_STAGES];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            ml_prod_ff[i] <= PROD_W'(dv_a[i]) * PROD_W'(dv_q_ff[DIV_STAGES]);
         end
         ml_carry_ff <= dv_carry_ff[DIV_STAGES];
      end
   end

   // round half up, restore sign, clear a zero-length vector
   logic [2:0]            ml_neg;
   logic                  ml_zero;
   logic [2:0][WORD_W-1:0] unit_in;

   assign ml_neg  = ml_carry_ff[3*A_W+3:3*A_W+1];
   assign ml_zero = ml_carry_ff[3*A_W];

   always_comb begin
      logic [PROD_W-1:0] rnd;
      logic [WORD_W-1:0] qm;
      for (int i = 0; i < 3; i++) begin
         rnd = ml_prod_ff[i] + (PROD_W'(1) << (RECIP_ONE_POS - 1 - FRAC_BITS));
         qm  = WORD_W'(rnd >> (RECIP_ONE_POS - FRAC_BITS));
         if (ml_zero) unit_in[i] = '0;
         else if (ml_neg[i]) unit_in[i] = -qm;
         else unit_in[i] = qm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else if (advance) out_valid <= ml_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_unit.x <= unit_in[0];
         out_unit.y <= unit_in[1];
         out_unit.z <= unit_in[2];
         out_zero   <= ml_zero;
         out_side   <= ml_carry_ff[CW-1:3*A_W+4];
      end
   end

endmodule

### src/lav_chk.sv
`timescale 1ns / 1ps

module lav_chk (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input lav_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lav_pkg::rsp_type rsp_data
);
   import lav_pkg::*;

   // a stalled row holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp row changed under stall");

   // never a fourth row code
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.row_index == ROW_RIGHT || rsp_data.row_index == ROW_UP ||
                     rsp_data.row_index == ROW_FWD))
      else $error("bad row index");

   // last_row marks the forward row only
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_row == (rsp_data.row_index == ROW_FWD)))
      else $error("last_row mismatch");

   // rows of one request follow in order with no gap
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_row |=>
         rsp_valid && rsp_data.row_index == $past(rsp_data.row_index) + 2'd1)
      else $error("row sequence broken");

   // degenerate flag is the same on every row of a request
   a_deg_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_row |=>
         rsp_data.degenerate == $past(rsp_data.degenerate))
      else $error("degenerate changed within a request");

endmodule

bind look_at_view_matrix lav_chk u_lav_chk (.*);

### test/look_at_view_matrix_tb.sv
`timescale 1ns / 1ps

module look_at_view_matrix_tb;
   import lav_pkg::*;

   localparam int FRAC   = FRAC_BITS_DEF;
   localparam int WD_LIM = 20000;
   localparam int N_RAND = 220;

   localparam word_type ONE = 32'sh1_0000;
   localparam word_type MX  = 32'sh7FFF_FFFF;
   localparam word_type MN  = 32'sh8000_0000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_reqs[$];
   rsp_type expected_rows[$];
   int      n_errors = 0;
   int      n_rows = 0;
   int      n_reqs = 0;
   int      n_degen = 0;
   int      idle_cnt = 0;
   bit      stim_done = 1'b0;

   // stall as sampled at the last rising edge
   logic req_stall_s = 1'b0;

   look_at_view_matrix dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [63:0] int_sqrt(logic [63:0] s);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s = s - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // unit vector of v; returns 1 when v is zero
   function automatic bit unit_vec(input longint v[3], output longint u[3]);
      logic [63:0] mag[3], a[3], m, s, len, r, q;
      int bl;
      m = 0; s = 0; bl = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = v[i] < 0 ? -v[i] : v[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         for (int i = 0; i < 3; i++) u[i] = 0;
         return 1'b1;
      end
      while (bl < 64 && (m >> bl) != 0) bl++;
      for (int i = 0; i < 3; i++) begin
         a[i] = bl > 30 ? mag[i] >> (bl - 30) : mag[i] << (30 - bl);
         s = s + a[i] * a[i];
      end
      len = int_sqrt(s);
      r = ((64'd1 << 61) + (len >> 1)) / len;
      for (int i = 0; i < 3; i++) begin
         q = (a[i] * r + (64'd1 << (60 - FRAC))) >> (61 - FRAC);
         u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1'b0;
   endfunction

   function automatic void cross_prod(input longint p[3], input longint q[3],
                                      output longint c[3]);
      c[0] = p[1] * q[2] - p[2] * q[1];
      c[1] = p[2] * q[0] - p[0] * q[2];
      c[2] = p[0] * q[1] - p[1] * q[0];
   endfunction

   function automatic word_type eye_dot(input longint e[3], input longint u[3]);
      longint sum;
      logic [63:0] mag, q;
      sum = e[0] * u[0] + e[1] * u[1] + e[2] * u[2];
      mag = sum < 0 ? -sum : sum;
      q = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
      if (sum < 0) return q > 64'h8000_0000 ? 32'h8000_0000 : word_type'(-longint'(q));
      return q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : word_type'(q);
   endfunction

   // queue the three rows a request should produce
   task automatic predict_rows(input req_type rq);
      longint eye[3], diff[3], upv[3], tmp[3], rows[3][3], u[3];
      bit deg;
      rsp_type rs;
      eye[0] = rq.eye_x; eye[1] = rq.eye_y; eye[2] = rq.eye_z;
      upv[0] = rq.up_x;  upv[1] = rq.up_y;  upv[2] = rq.up_z;
      diff[0] = longint'(rq.eye_x) - longint'(rq.target_x);
      diff[1] = longint'(rq.eye_y) - longint'(rq.target_y);
      diff[2] = longint'(rq.eye_z) - longint'(rq.target_z);
      deg = unit_vec(diff, u);
      rows[ROW_FWD] = u;
      cross_prod(upv, rows[ROW_FWD], tmp);
      deg = unit_vec(tmp, u) | deg;
      rows[ROW_RIGHT] = u;
      cross_prod(rows[ROW_FWD], rows[ROW_RIGHT], tmp);
      deg = unit_vec(tmp, u) | deg;
      rows[ROW_UP] = u;
      if (deg) n_degen++;
      for (int k = 0; k < 3; k++) begin
         rs.row_index  = 2'(k);
         rs.col_x      = word_type'(rows[k][0]);
         rs.col_y      = word_type'(rows[k][1]);
         rs.col_z      = word_type'(rows[k][2]);
         rs.col_w      = eye_dot(eye, rows[k]);
         rs.last_row   = (2'(k) == ROW_FWD);
         rs.degenerate = deg;
         expected_rows.push_back(rs);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at row %0d: %s got %h want %h", n_rows, what, got, want);
      n_errors++;
   endtask

   function automatic word_type rand_word(int kind);
      case (kind)
         0: return word_type'($urandom);
         1: return word_type'($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
         2: return word_type'($urandom_range(0, 8)) - 32'sd4;
         default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      endcase
   endfunction

   function automatic req_type make_req(word_type ex, word_type ey, word_type ez,
      word_type tx, word_type ty, word_type tz, word_type ux, word_type uy,
      word_type uz);
      req_type r;
      r = {ex, ey, ez, tx, ty, tz, ux, uy, uz};
      return r;
   endfunction

   // stimulus: directed corners then mixed random
   initial begin
      req_type r;
      int k;
      pending_reqs.push_back(make_req(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0));
      pending_reqs.push_back(make_req(3 * ONE, 2 * ONE, ONE, 0, 0, 0, 0, ONE, 0));
      // eye equals target
      pending_reqs.push_back(make_req(ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0));
      // up parallel to forward
      pending_reqs.push_back(make_req(0, 4 * ONE, 0, 0, 0, 0, 0, ONE, 0));
      // zero up
      pending_reqs.push_back(make_req(ONE, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(MX, MX, MX, MN, MN, MN, MX, MN, MX));
      pending_reqs.push_back(make_req(MN, MN, MN, MX, MX, MX, MN, MX, MN));
      pending_reqs.push_back(make_req(MX, MN, MX, MN, MX, MN, MN, MN, MN));
      pending_reqs.push_back(make_req(MN, 0, MX, 0, MX, MN, MX, MX, 1));
      pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 0, 0, 0, 1));
      pending_reqs.push_back(make_req(-1, -1, -1, 0, 0, 0, -1, 1, -1));
      pending_reqs.push_back(make_req(-32'sd1, 32'sd0, 32'sd0, MX, 0, 0, 0, MX, 0));
      pending_reqs.push_back(make_req(MX, MX, MX, 0, 0, 0, 0, ONE, 0));
      pending_reqs.push_back(make_req(MN, MN, MN, 1, 1, 1, 0, 0, ONE));
      pending_reqs.push_back(make_req(32'sh5555_5555, 32'shAAAA_AAAA, 0, 0, 0, 0,
                                      32'shAAAA_AAAA, 32'sh5555_5555, 1));
      for (int n = 0; n < N_RAND; n++) begin
         k = $urandom_range(0, 9);
         for (int f = 0; f < 9; f++)
            r[32*f +: 32] = rand_word(k < 4 ? 0 : k < 7 ? 1 : k < 9 ? 2 : 3);
         // occasional degenerate shapes
         if ($urandom_range(0, 15) == 0) begin
            r.target_x = r.eye_x; r.target_y = r.eye_y; r.target_z = r.eye_z;
         end else if ($urandom_range(0, 15) == 0) begin
            r.up_x = r.eye_x - r.target_x;
            r.up_y = r.eye_y - r.target_y;
            r.up_z = r.eye_z - r.target_z;
         end
         pending_reqs.push_back(r);
      end
   end

   // driver
   int req_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall_s) begin
         if (req_valid) n_reqs++;
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs[0];
            predict_rows(pending_reqs.pop_front());
            req_valid <= 1'b1;
            req_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
         end else begin
            req_valid <= 1'b0;
            stim_done <= 1'b1;
         end
      end
   end

   // monitor and watchdog
   int rsp_gap = 0;
   always @(posedge clock) begin
      req_stall_s <= req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            idle_cnt <= 0;
            if (expected_rows.size() == 0) begin
               $display("unexpected row transfer");
               n_errors++;
            end else begin
               rsp_type w;
               w = expected_rows.pop_front();
               if (rsp_data.row_index != w.row_index)
                  report_mismatch("row_index", 32'(rsp_data.row_index), 32'(w.row_index));
               if (rsp_data.col_x != w.col_x) report_mismatch("col_x", rsp_data.col_x, w.col_x);
               if (rsp_data.col_y != w.col_y) report_mismatch("col_y", rsp_data.col_y, w.col_y);
               if (rsp_data.col_z != w.col_z) report_mismatch("col_z", rsp_data.col_z, w.col_z);
               if (rsp_data.col_w != w.col_w) report_mismatch("col_w", rsp_data.col_w, w.col_w);
               if (rsp_data.last_row != w.last_row)
                  report_mismatch("last_row", 32'(rsp_data.last_row), 32'(w.last_row));
               if (rsp_data.degenerate != w.degenerate)
                  report_mismatch("degenerate", 32'(rsp_data.degenerate),
                                  32'(w.degenerate));
            end
            n_rows++;
         end else if (req_valid && !req_stall) begin
            idle_cnt <= 0;
         end else begin
            idle_cnt <= idle_cnt + 1;
         end
      end
   end

   // receiver stall pattern, changed at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // reset, end of run and timeout
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (!(stim_done && expected_rows.size() == 0) && idle_cnt < WD_LIM)
         @(posedge clock);
      if (idle_cnt >= WD_LIM) begin
         $display("timeout with %0d rows outstanding", expected_rows.size());
         $display("FAILED: results differ");
      end else begin
         repeat (150) @(posedge clock);
         $display("covered %0d requests, %0d rows, %0d degenerate requests",
                  n_reqs, n_rows, n_degen);
         if (n_errors == 0 && expected_rows.size() == 0)
            $display("PASSED: all results match");
         else
            $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### sim.f
src/lav_pkg.sv
src/lav_nrm.sv
src/look_at_view_matrix.sv
src/lav_chk.sv
test/look_at_view_matrix_tb.sv
